/* design/sscp_pkg.sv */
package sscp_pkg;

	localparam int CW = 32;
	localparam int FB = 16;
	localparam int FW = FB + 1;
	localparam int DW = CW + 1;
	localparam int PW = 2 * DW;
	localparam int SW = PW + 2;
	localparam int QW = 2 * SW + 1;
	localparam int NW = SW + FB + 3;
	localparam int MD = 17;
	localparam int MUL_LAT = (SW + MD - 1) / MD;
	localparam int DIV_LAT = FB + 2;
	localparam logic [FW-1:0] FRAC_ONE = FW'(1) << FB;

	typedef logic signed [CW-1:0] coord_t;
	typedef logic signed [DW-1:0] diff_t;
	typedef logic signed [PW-1:0] prod_t;
	typedef logic signed [SW-1:0] dot_t;
	typedef logic signed [QW-1:0] quad_t;
	typedef logic signed [NW-1:0] num_t;
	typedef logic signed [DW+FW:0] step_t;

	typedef struct packed {
		logic signed [CW-1:0] a_start_x;
		logic signed [CW-1:0] a_start_y;
		logic signed [CW-1:0] a_start_z;
		logic signed [CW-1:0] a_end_x;
		logic signed [CW-1:0] a_end_y;
		logic signed [CW-1:0] a_end_z;
		logic signed [CW-1:0] b_start_x;
		logic signed [CW-1:0] b_start_y;
		logic signed [CW-1:0] b_start_z;
		logic signed [CW-1:0] b_end_x;
		logic signed [CW-1:0] b_end_y;
		logic signed [CW-1:0] b_end_z;
	} seg_req_t;

	typedef struct packed {
		logic signed [CW-1:0] near_a_x;
		logic signed [CW-1:0] near_a_y;
		logic signed [CW-1:0] near_a_z;
		logic signed [CW-1:0] near_b_x;
		logic signed [CW-1:0] near_b_y;
		logic signed [CW-1:0] near_b_z;
		logic [FW-1:0] frac_on_a;
		logic [FW-1:0] frac_on_b;
	} seg_rsp_t;

	typedef struct packed {
		coord_t [2:0] as;
		coord_t [2:0] bs;
		diff_t [2:0] v1;
		diff_t [2:0] v2;
		dot_t a;
		dot_t b;
		dot_t c;
		dot_t d;
		dot_t e;
	} side_t;

endpackage

/* design/sscp_dly.sv */
module sscp_dly #(
	parameter int W = 8,
	parameter int N = 1
) (
	input  logic         clk,
	input  logic         en,
	input  logic [W-1:0] d,
	output logic [W-1:0] q
);

	logic [W-1:0] pipe_q [N];

	always_ff @(posedge clk) begin
		if (en) begin
			pipe_q[0] <= d;
			for (int i = 1; i < N; i++) begin
				pipe_q[i] <= pipe_q[i-1];
			end
		end
	end

	assign q = pipe_q[N-1];

endmodule

/* design/sscp_mul.sv */
module sscp_mul #(
	parameter int WA = 68,
	parameter int WB = 68,
	parameter int D  = 17
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    en,
	input  logic                    in_vld,
	input  logic signed [WA-1:0]    a,
	input  logic signed [WB-1:0]    b,
	output logic                    out_vld,
	output logic signed [WA+WB-1:0] p
);

	localparam int N   = (WB + D - 1) / D;
	localparam int WBP = N * D;
	localparam int WP  = WA + WBP;

	logic [N-1:0]          vld_q;
	logic signed [WA-1:0]  a_q   [N];
	logic signed [WBP-1:0] b_q   [N];
	logic signed [WP-1:0]  acc_q [N];

	logic signed [WA-1:0]  a_cur   [N];
	logic signed [WBP-1:0] b_cur   [N];
	logic signed [WP-1:0]  acc_cur [N];
	logic signed [WA+D:0]  pp_c    [N];
	logic signed [WP-1:0]  acc_c   [N];

	always_comb begin
		a_cur[0] = a;
		b_cur[0] = WBP'(b);
		acc_cur[0] = '0;
		for (int k = 1; k < N; k++) begin
			a_cur[k] = a_q[k-1];
			b_cur[k] = b_q[k-1];
			acc_cur[k] = acc_q[k-1];
		end
		// one digit of b per stage, top digit carries the sign
		for (int k = 0; k < N; k++) begin
			pp_c[k] = (k == N - 1) ? a_cur[k] * $signed(b_cur[k][k*D +: D])
				: a_cur[k] * $signed({1'b0, b_cur[k][k*D +: D]});
			acc_c[k] = acc_cur[k] + (WP'(pp_c[k]) <<< (k * D));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[N-2:0], in_vld};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < N; k++) begin
				a_q[k] <= a_cur[k];
				b_q[k] <= b_cur[k];
				acc_q[k] <= acc_c[k];
			end
		end
	end

	assign out_vld = vld_q[N-1];
	assign p = acc_q[N-1][WA+WB-1:0];

endmodule

/* design/sscp_div.sv */
module sscp_div #(
	parameter int W = 8,
	parameter int F = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                en,
	input  logic                in_vld,
	input  logic signed [W-1:0] num,
	input  logic signed [W-1:0] den,
	output logic                out_vld,
	output logic [F:0]          quo
);

	localparam int N = F + 1;

	logic signed [W:0] num_x, den_x, num_n, den_n;
	logic              zero_c, one_c;

	logic [N-1:0] vld_q, fix_q, one_q;
	logic [W-1:0] den_q [N];
	logic [W-1:0] rem_q [N];
	logic [F-1:0] quo_q [N];

	logic [W:0]   rem2_c [N];
	logic         ge_c   [N];
	logic [W-1:0] rem_c  [N];

	logic         vld_out_q;
	logic [F:0]   quo_out_q;

	assign num_x = (W+1)'(num);
	assign den_x = (W+1)'(den);

	// make the divisor positive
	always_comb begin
		if (den[W-1]) begin
			num_n = -num_x;
			den_n = -den_x;
		end else begin
			num_n = num_x;
			den_n = den_x;
		end
	end

	assign zero_c = (den_n == '0) || num_n[W] || (num_n == '0);
	assign one_c = !zero_c && (num_n >= den_n);

	// restoring step, one quotient bit per stage
	always_comb begin
		for (int k = 0; k < N; k++) begin
			rem2_c[k] = {rem_q[k], 1'b0};
			ge_c[k] = rem2_c[k] >= {1'b0, den_q[k]};
			rem_c[k] = ge_c[k] ? W'(rem2_c[k] - {1'b0, den_q[k]}) : rem2_c[k][W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
			vld_out_q <= 1'b0;
		end else if (en) begin
			vld_q <= {vld_q[N-2:0], in_vld};
			vld_out_q <= vld_q[N-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			den_q[0] <= den_n[W-1:0];
			rem_q[0] <= num_n[W-1:0];
			quo_q[0] <= '0;
			fix_q[0] <= zero_c || one_c;
			one_q[0] <= one_c;
			for (int k = 1; k < N; k++) begin
				den_q[k] <= den_q[k-1];
				rem_q[k] <= rem_c[k-1];
				quo_q[k] <= {quo_q[k-1][F-2:0], ge_c[k-1]};
				fix_q[k] <= fix_q[k-1];
				one_q[k] <= one_q[k-1];
			end
			if (fix_q[N-1]) begin
				quo_out_q <= one_q[N-1] ? (F+1)'(1) << F : '0;
			end else begin
				quo_out_q <= {1'b0, quo_q[N-1]} + (F+1)'(ge_c[N-1]);
			end
		end
	end

	assign out_vld = vld_out_q;
	assign quo = quo_out_q;

endmodule

/* design/segment_segment_closest_points.sv */
// channel  | direction | handshake          | payload
// req      | in        | req_valid/req_stall | sscp_pkg::seg_req_t
// rsp      | out       | rsp_valid/rsp_stall | sscp_pkg::seg_rsp_t
// cfg      | in        | cfg_valid/cfg_ready | parallel_limit, 32 bits
//
// one request per cycle unless the pipeline is stalled
// latency set by the three 18-stage dividers and the digit-pipelined 68-bit multipliers
// reset clears all valid bits and sets parallel_limit to 0
// a stalled response freezes the whole pipeline, req_stall follows at once
// cfg_ready is always high

module segment_segment_closest_points (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               req_valid,
	output logic               req_stall,
	input  sscp_pkg::seg_req_t req,
	output logic               rsp_valid,
	input  logic               rsp_stall,
	output sscp_pkg::seg_rsp_t rsp,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [31:0]        cfg_data
);

	logic en;
	logic [31:0] limit_q;

	sscp_pkg::coord_t [2:0] as_c, ae_c, bs_c, be_c;

	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6, vld_s7;
	logic vld_s8, vld_s9, vld_s10, vld_s11;
	logic vld_m, vld_d1, vld_d2, vld_d3;

	sscp_pkg::coord_t [2:0] as_s1, bs_s1, as_s2, bs_s2;
	sscp_pkg::diff_t [2:0]  v1_s1, v2_s1, r_s1, v1_s2, v2_s2;
	sscp_pkg::prod_t [2:0]  paa_s2, pab_s2, pcc_s2, pad_s2, pae_s2;

	sscp_pkg::side_t side_s3, side_m, side_s4, side_s5, side_d1, side_s6, side_s7;
	sscp_pkg::side_t side_d2, side_s8, side_s9, side_d3;

	logic signed [2*sscp_pkg::SW-1:0] ac_m, bb_m, cd_m, be_m;
	sscp_pkg::quad_t det_s4, num1_s4, num1_s5, den1_s5, mag_c;

	logic [sscp_pkg::FW-1:0] s0_d, t_d, s_d, t_s8, t_s9, t_d3, s_s10, t_s10;
	sscp_pkg::num_t pb_s6, num2_s7, den2_s7, pt_s8, num3_s9, den3_s9;

	sscp_pkg::coord_t [2:0] as_s10, bs_s10;
	sscp_pkg::step_t [2:0]  pa_s10, pb_s10;
	sscp_pkg::step_t        half_c;
	sscp_pkg::seg_rsp_t     rsp_s11;

	assign en = !(vld_s11 && rsp_stall);
	assign req_stall = !en;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			limit_q <= cfg_data;
		end
	end

	assign as_c = {req.a_start_z, req.a_start_y, req.a_start_x};
	assign ae_c = {req.a_end_z, req.a_end_y, req.a_end_x};
	assign bs_c = {req.b_start_z, req.b_start_y, req.b_start_x};
	assign be_c = {req.b_end_z, req.b_end_y, req.b_end_x};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
			vld_s7 <= 1'b0;
			vld_s8 <= 1'b0;
			vld_s9 <= 1'b0;
			vld_s10 <= 1'b0;
			vld_s11 <= 1'b0;
		end else if (en) begin
			vld_s1 <= req_valid;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_m;
			vld_s5 <= vld_s4;
			vld_s6 <= vld_d1;
			vld_s7 <= vld_s6;
			vld_s8 <= vld_d2;
			vld_s9 <= vld_s8;
			vld_s10 <= vld_d3;
			vld_s11 <= vld_s10;
		end
	end

	// direction vectors, dot products, sums
	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				v1_s1[i] <= sscp_pkg::diff_t'(ae_c[i]) - sscp_pkg::diff_t'(as_c[i]);
				v2_s1[i] <= sscp_pkg::diff_t'(be_c[i]) - sscp_pkg::diff_t'(bs_c[i]);
				r_s1[i] <= sscp_pkg::diff_t'(as_c[i]) - sscp_pkg::diff_t'(bs_c[i]);
				paa_s2[i] <= sscp_pkg::prod_t'(v1_s1[i]) * sscp_pkg::prod_t'(v1_s1[i]);
				pab_s2[i] <= sscp_pkg::prod_t'(v1_s1[i]) * sscp_pkg::prod_t'(v2_s1[i]);
				pcc_s2[i] <= sscp_pkg::prod_t'(v2_s1[i]) * sscp_pkg::prod_t'(v2_s1[i]);
				pad_s2[i] <= sscp_pkg::prod_t'(v1_s1[i]) * sscp_pkg::prod_t'(r_s1[i]);
				pae_s2[i] <= sscp_pkg::prod_t'(v2_s1[i]) * sscp_pkg::prod_t'(r_s1[i]);
			end
			as_s1 <= as_c;
			bs_s1 <= bs_c;
			as_s2 <= as_s1;
			bs_s2 <= bs_s1;
			v1_s2 <= v1_s1;
			v2_s2 <= v2_s1;
			side_s3.as <= as_s2;
			side_s3.bs <= bs_s2;
			side_s3.v1 <= v1_s2;
			side_s3.v2 <= v2_s2;
			side_s3.a <= sscp_pkg::dot_t'(paa_s2[0]) + sscp_pkg::dot_t'(paa_s2[1])
				+ sscp_pkg::dot_t'(paa_s2[2]);
			side_s3.b <= sscp_pkg::dot_t'(pab_s2[0]) + sscp_pkg::dot_t'(pab_s2[1])
				+ sscp_pkg::dot_t'(pab_s2[2]);
			side_s3.c <= sscp_pkg::dot_t'(pcc_s2[0]) + sscp_pkg::dot_t'(pcc_s2[1])
				+ sscp_pkg::dot_t'(pcc_s2[2]);
			side_s3.d <= sscp_pkg::dot_t'(pad_s2[0]) + sscp_pkg::dot_t'(pad_s2[1])
				+ sscp_pkg::dot_t'(pad_s2[2]);
			side_s3.e <= sscp_pkg::dot_t'(pae_s2[0]) + sscp_pkg::dot_t'(pae_s2[1])
				+ sscp_pkg::dot_t'(pae_s2[2]);
		end
	end

	// determinant and first numerator
	sscp_mul #(.WA(sscp_pkg::SW), .WB(sscp_pkg::SW), .D(sscp_pkg::MD)) u_mul_ac (
		.clk(clk), .arst_n(arst_n), .en(en), .in_vld(vld_s3),
		.a(side_s3.a), .b(side_s3.c), .out_vld(vld_m), .p(ac_m)
	);
	sscp_mul #(.WA(sscp_pkg::SW), .WB(sscp_pkg::SW), .D(sscp_pkg::MD)) u_mul_bb (
		.clk(clk), .arst_n(arst_n), .en(en), .in_vld(vld_s3),
		.a(side_s3.b), .b(side_s3.b), .out_vld(), .p(bb_m)
	);
	sscp_mul #(.WA(sscp_pkg::SW), .WB(sscp_pkg::SW), .D(sscp_pkg::MD)) u_mul_cd (
		.clk(clk), .arst_n(arst_n), .en(en), .in_vld(vld_s3),
		.a(side_s3.c), .b(side_s3.d), .out_vld(), .p(cd_m)
	);
	sscp_mul #(.WA(sscp_pkg::SW), .WB(sscp_pkg::SW), .D(sscp_pkg::MD)) u_mul_be (
		.clk(clk), .arst_n(arst_n), .en(en), .in_vld(vld_s3),
		.a(side_s3.b), .b(side_s3.e), .out_vld(), .p(be_m)
	);
	sscp_dly #(.W($bits(sscp_pkg::side_t)), .N(sscp_pkg::MUL_LAT)) u_dly_m (
		.clk(clk), .en(en), .d(side_s3), .q(side_m)
	);

	assign mag_c = det_s4[sscp_pkg::QW-1] ? -det_s4 : det_s4;

	always_ff @(posedge clk) begin
		if (en) begin
			det_s4 <= sscp_pkg::quad_t'(bb_m) - sscp_pkg::quad_t'(ac_m);
			num1_s4 <= sscp_pkg::quad_t'(cd_m) - sscp_pkg::quad_t'(be_m);
			side_s4 <= side_m;
			// nearly parallel: zero divisor gives s = 0
			den1_s5 <= ($unsigned(mag_c) <= sscp_pkg::QW'(limit_q)) ? '0 : det_s4;
			num1_s5 <= num1_s4;
			side_s5 <= side_s4;
		end
	end

	sscp_div #(.W(sscp_pkg::QW), .F(sscp_pkg::FB)) u_div_s0 (
		.clk(clk), .arst_n(arst_n), .en(en), .in_vld(vld_s5),
		.num(num1_s5), .den(den1_s5), .out_vld(vld_d1), .quo(s0_d)
	);
	sscp_dly #(.W($bits(sscp_pkg::side_t)), .N(sscp_pkg::DIV_LAT)) u_dly_d1 (
		.clk(clk), .en(en), .d(side_s5), .q(side_d1)
	);

	// t from the first s
	always_ff @(posedge clk) begin
		if (en) begin
			pb_s6 <= sscp_pkg::num_t'($signed({1'b0, s0_d})) * sscp_pkg::num_t'(side_d1.b);
			side_s6 <= side_d1;
			num2_s7 <= (sscp_pkg::num_t'(side_s6.e) <<< sscp_pkg::FB) + pb_s6;
			den2_s7 <= sscp_pkg::num_t'(side_s6.c) <<< sscp_pkg::FB;
			side_s7 <= side_s6;
		end
	end

	sscp_div #(.W(sscp_pkg::NW), .F(sscp_pkg::FB)) u_div_t (
		.clk(clk), .arst_n(arst_n), .en(en), .in_vld(vld_s7),
		.num(num2_s7), .den(den2_s7), .out_vld(vld_d2), .quo(t_d)
	);
	sscp_dly #(.W($bits(sscp_pkg::side_t)), .N(sscp_pkg::DIV_LAT)) u_dly_d2 (
		.clk(clk), .en(en), .d(side_s7), .q(side_d2)
	);

	// final s from t
	always_ff @(posedge clk) begin
		if (en) begin
			pt_s8 <= sscp_pkg::num_t'($signed({1'b0, t_d})) * sscp_pkg::num_t'(side_d2.b);
			t_s8 <= t_d;
			side_s8 <= side_d2;
			num3_s9 <= pt_s8 - (sscp_pkg::num_t'(side_s8.d) <<< sscp_pkg::FB);
			den3_s9 <= sscp_pkg::num_t'(side_s8.a) <<< sscp_pkg::FB;
			t_s9 <= t_s8;
			side_s9 <= side_s8;
		end
	end

	sscp_div #(.W(sscp_pkg::NW), .F(sscp_pkg::FB)) u_div_s (
		.clk(clk), .arst_n(arst_n), .en(en), .in_vld(vld_s9),
		.num(num3_s9), .den(den3_s9), .out_vld(vld_d3), .quo(s_d)
	);
	sscp_dly #(.W($bits(sscp_pkg::side_t)), .N(sscp_pkg::DIV_LAT)) u_dly_d3 (
		.clk(clk), .en(en), .d(side_s9), .q(side_d3)
	);
	sscp_dly #(.W(sscp_pkg::FW), .N(sscp_pkg::DIV_LAT)) u_dly_t (
		.clk(clk), .en(en), .d(t_s9), .q(t_d3)
	);

	// closest points, rounded half up
	assign half_c = sscp_pkg::step_t'(1) <<< (sscp_pkg::FB - 1);

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				pa_s10[i] <= sscp_pkg::step_t'(side_d3.v1[i])
					* sscp_pkg::step_t'($signed({1'b0, s_d}));
				pb_s10[i] <= sscp_pkg::step_t'(side_d3.v2[i])
					* sscp_pkg::step_t'($signed({1'b0, t_d3}));
			end
			as_s10 <= side_d3.as;
			bs_s10 <= side_d3.bs;
			s_s10 <= s_d;
			t_s10 <= t_d3;
			rsp_s11.near_a_x <= as_s10[0]
				+ sscp_pkg::CW'((pa_s10[0] + half_c) >>> sscp_pkg::FB);
			rsp_s11.near_a_y <= as_s10[1]
				+ sscp_pkg::CW'((pa_s10[1] + half_c) >>> sscp_pkg::FB);
			rsp_s11.near_a_z <= as_s10[2]
				+ sscp_pkg::CW'((pa_s10[2] + half_c) >>> sscp_pkg::FB);
			rsp_s11.near_b_x <= bs_s10[0]
				+ sscp_pkg::CW'((pb_s10[0] + half_c) >>> sscp_pkg::FB);
			rsp_s11.near_b_y <= bs_s10[1]
				+ sscp_pkg::CW'((pb_s10[1] + half_c) >>> sscp_pkg::FB);
			rsp_s11.near_b_z <= bs_s10[2]
				+ sscp_pkg::CW'((pb_s10[2] + half_c) >>> sscp_pkg::FB);
			rsp_s11.frac_on_a <= s_s10;
			rsp_s11.frac_on_b <= t_s10;
		end
	end

	assign rsp_valid = vld_s11;
	assign rsp = rsp_s11;

	a_req_enters: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && !req_stall |=> vld_s1)
		else $error("accepted request did not enter stage 1");

	a_rsp_held: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_s11))
		else $error("stalled response lost");

	a_frac_range: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> rsp.frac_on_a <= sscp_pkg::FRAC_ONE
			&& rsp.frac_on_b <= sscp_pkg::FRAC_ONE)
		else $error("parameter above one");

	a_stall_freeze: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> $stable(vld_s5) && $stable(vld_d2))
		else $error("pipeline moved during stall");

endmodule
